// ----- design/psch_pkg.sv -----
// Package for the preemptive priority scheduler: sizes, item codes, the job
// record type and small time helpers. No dependencies.
package psch_pkg;

  localparam int MAX_JOBS  = 16;
  localparam int TIME_BITS = 16;
  localparam int IDX_W     = $clog2(MAX_JOBS);
  localparam int CNT_W     = $clog2(MAX_JOBS + 1);
  localparam int OUT_TW    = 16;
  localparam int WIDE_BITS = (TIME_BITS > OUT_TW) ? TIME_BITS : OUT_TW;

  localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

  typedef enum logic [1:0] {
    MODE_LOAD  = 2'd0,
    MODE_TICK  = 2'd1,
    MODE_CLEAR = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    LERR_OK   = 2'd0,
    LERR_FULL = 2'd1,
    LERR_ZERO = 2'd2
  } load_err_e;

  typedef struct packed {
    logic [7:0]        id;
    logic [OUT_TW-1:0] arrival;
    logic [7:0]        burst;
    logic [7:0]        prio;
    logic [7:0]        remaining;
  } job_t;

  function automatic logic [WIDE_BITS-1:0] widen_time(input logic [TIME_BITS-1:0] t);
    widen_time = WIDE_BITS'(t);
  endfunction

  function automatic logic [OUT_TW-1:0] out_time(input logic [WIDE_BITS-1:0] t);
    out_time = t[OUT_TW-1:0];
  endfunction

endpackage

// ----- design/psch_table.sv -----
// Job table memory: one write port and one registered read port.
// Depends on psch_pkg for the job record type and table depth.
module psch_table (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [psch_pkg::IDX_W-1:0] waddr_i,
  input  psch_pkg::job_t        wdata_i,
  input  logic                  re_i,
  input  logic [psch_pkg::IDX_W-1:0] raddr_i,
  output psch_pkg::job_t        rdata_o
);

  psch_pkg::job_t mem [psch_pkg::MAX_JOBS];
  psch_pkg::job_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/psch_pick.sv -----
// Shared compare unit: decides whether a scanned job beats the current best.
// Depends on psch_pkg for the job record type and time widths.
module psch_pick (
  input  psch_pkg::job_t                 cand_i,
  input  psch_pkg::job_t                 best_i,
  input  logic                           best_vld_i,
  input  logic [psch_pkg::TIME_BITS-1:0] now_i,
  output logic                           take_o
);

  logic eligible;
  logic better;

  assign eligible = (cand_i.remaining != 8'd0) &&
                    (psch_pkg::WIDE_BITS'(cand_i.arrival) <= psch_pkg::widen_time(now_i));
  assign better   = (cand_i.prio < best_i.prio) ||
                    ((cand_i.prio == best_i.prio) && (cand_i.arrival < best_i.arrival));
  assign take_o   = eligible && (!best_vld_i || better);

endmodule

// ----- design/preemptive_priority_scheduler.sv -----
// Top level of the preemptive priority scheduler: sequencer, counters, time
// and result register. Uses psch_pkg, psch_table and psch_pick.
//
// Usage: one input word per request on the in channel (valid/ready), one
// result word per request on the out channel (valid/ready). Mode load
// appends a job to the table, mode tick runs the best eligible job for one
// time unit, mode clear empties the table and sets time to zero.
// A load, clear or unused-mode word goes from idle straight to the result
// step, and the next word is taken once the block is back in idle. A tick
// scans the table one entry per cycle through the single read port of the
// job memory and the shared compare unit, then passes through the update
// step, a wait step when the job finishes, and the result step.
// The block accepts one word at a time; it takes the next word while a
// finished result still waits in the output register, and holds its final
// result step until that register is free when the receiver stalls.
// Reset clears the job and done counts, time and all handshake state; the
// table contents stay undefined and are never read before being written.
module preemptive_priority_scheduler (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  mode_i,
  input  logic [7:0]  job_id_i,
  input  logic [15:0] arrival_i,
  input  logic [7:0]  burst_i,
  input  logic [7:0]  priority_req_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  ran_job_o,
  output logic        idle_o,
  output logic [15:0] tick_time_o,
  output logic        finished_o,
  output logic [15:0] completion_o,
  output logic [15:0] turnaround_o,
  output logic [15:0] waiting_o,
  output logic        all_done_o,
  output logic [1:0]  load_error_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE,
    ST_WAIT,
    ST_RESP
  } state_e;

  state_e                           state_q;
  logic [psch_pkg::CNT_W-1:0]       job_cnt_q;
  logic [psch_pkg::CNT_W-1:0]       done_cnt_q;
  logic [psch_pkg::TIME_BITS-1:0]   now_q;
  logic [psch_pkg::TIME_BITS-1:0]   now_next;
  logic [psch_pkg::CNT_W-1:0]       idx_q;
  logic                             rd_vld_q;
  logic [psch_pkg::IDX_W-1:0]       rd_idx_q;
  psch_pkg::job_t                   best_q;
  logic                             best_vld_q;
  logic [psch_pkg::IDX_W-1:0]       best_idx_q;
  logic [psch_pkg::WIDE_BITS-1:0]   tat_q;
  logic [psch_pkg::WIDE_BITS-1:0]   burst_w;

  logic [7:0]  res_ran_q;
  logic        res_idle_q;
  logic [15:0] res_time_q;
  logic        res_fin_q;
  logic [15:0] res_comp_q;
  logic [15:0] res_tat_q;
  logic [15:0] res_wait_q;
  logic [1:0]  res_lerr_q;

  logic        out_valid_q;
  logic [7:0]  out_ran_q;
  logic        out_idle_q;
  logic [15:0] out_time_q;
  logic        out_fin_q;
  logic [15:0] out_comp_q;
  logic [15:0] out_tat_q;
  logic [15:0] out_wait_q;
  logic        out_all_q;
  logic [1:0]  out_lerr_q;

  logic                       accept;
  logic                       load_ok;
  logic                       issue;
  logic                       take;
  logic                       we;
  logic [psch_pkg::IDX_W-1:0] waddr;
  psch_pkg::job_t             wdata;
  psch_pkg::job_t             rdata;
  logic                       resp_fire;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign load_ok    = (burst_i != 8'd0) && (job_cnt_q < psch_pkg::CNT_W'(psch_pkg::MAX_JOBS));
  assign issue      = (state_q == ST_SCAN) && (idx_q < job_cnt_q);
  assign now_next   = (now_q == psch_pkg::TIME_MAX) ? now_q : now_q + 1'b1;
  assign resp_fire  = (state_q == ST_RESP) && (!out_valid_q || out_ready_i);
  assign burst_w    = psch_pkg::WIDE_BITS'(best_q.burst);

  always_comb begin
    we    = 1'b0;
    waddr = best_idx_q;
    wdata = best_q;
    if (accept && (mode_i == psch_pkg::MODE_LOAD) && load_ok) begin
      we              = 1'b1;
      waddr           = job_cnt_q[psch_pkg::IDX_W-1:0];
      wdata.id        = job_id_i;
      wdata.arrival   = arrival_i;
      wdata.burst     = burst_i;
      wdata.prio      = priority_req_i;
      wdata.remaining = burst_i;
    end else if ((state_q == ST_UPDATE) && best_vld_q) begin
      we              = 1'b1;
      wdata.remaining = best_q.remaining - 8'd1;
    end
  end

  psch_table u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (issue),
    .raddr_i (idx_q[psch_pkg::IDX_W-1:0]),
    .rdata_o (rdata)
  );

  psch_pick u_pick (
    .cand_i     (rdata),
    .best_i     (best_q),
    .best_vld_i (best_vld_q),
    .now_i      (now_q),
    .take_o     (take)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      job_cnt_q   <= '0;
      done_cnt_q  <= '0;
      now_q       <= '0;
      idx_q       <= '0;
      rd_vld_q    <= 1'b0;
      rd_idx_q    <= '0;
      best_q      <= '0;
      best_vld_q  <= 1'b0;
      best_idx_q  <= '0;
      tat_q       <= '0;
      res_ran_q   <= '0;
      res_idle_q  <= 1'b0;
      res_time_q  <= '0;
      res_fin_q   <= 1'b0;
      res_comp_q  <= '0;
      res_tat_q   <= '0;
      res_wait_q  <= '0;
      res_lerr_q  <= '0;
      out_valid_q <= 1'b0;
      out_ran_q   <= '0;
      out_idle_q  <= 1'b0;
      out_time_q  <= '0;
      out_fin_q   <= 1'b0;
      out_comp_q  <= '0;
      out_tat_q   <= '0;
      out_wait_q  <= '0;
      out_all_q   <= 1'b0;
      out_lerr_q  <= '0;
    end else begin
      if (out_valid_q && out_ready_i && !resp_fire) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            res_ran_q  <= '0;
            res_idle_q <= 1'b0;
            res_fin_q  <= 1'b0;
            res_comp_q <= '0;
            res_tat_q  <= '0;
            res_wait_q <= '0;
            case (mode_i)
              psch_pkg::MODE_LOAD: begin
                res_time_q <= psch_pkg::out_time(psch_pkg::widen_time(now_q));
                state_q    <= ST_RESP;
                if (burst_i == 8'd0) begin
                  res_lerr_q <= psch_pkg::LERR_ZERO;
                end else if (!load_ok) begin
                  res_lerr_q <= psch_pkg::LERR_FULL;
                end else begin
                  res_lerr_q <= psch_pkg::LERR_OK;
                  job_cnt_q  <= job_cnt_q + 1'b1;
                end
              end
              psch_pkg::MODE_TICK: begin
                res_lerr_q <= psch_pkg::LERR_OK;
                res_time_q <= psch_pkg::out_time(psch_pkg::widen_time(now_q));
                idx_q      <= '0;
                rd_vld_q   <= 1'b0;
                best_vld_q <= 1'b0;
                state_q    <= ST_SCAN;
              end
              psch_pkg::MODE_CLEAR: begin
                res_lerr_q <= psch_pkg::LERR_OK;
                res_time_q <= '0;
                job_cnt_q  <= '0;
                done_cnt_q <= '0;
                now_q      <= '0;
                state_q    <= ST_RESP;
              end
              default: begin
                res_lerr_q <= psch_pkg::LERR_OK;
                res_time_q <= psch_pkg::out_time(psch_pkg::widen_time(now_q));
                state_q    <= ST_RESP;
              end
            endcase
          end
        end
        ST_SCAN: begin
          rd_vld_q <= issue;
          rd_idx_q <= idx_q[psch_pkg::IDX_W-1:0];
          if (issue) begin
            idx_q <= idx_q + 1'b1;
          end
          if (rd_vld_q && take) begin
            best_q     <= rdata;
            best_idx_q <= rd_idx_q;
            best_vld_q <= 1'b1;
          end
          if (!issue && !rd_vld_q) begin
            state_q <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          now_q <= now_next;
          if (!best_vld_q) begin
            res_idle_q <= 1'b1;
            state_q    <= ST_RESP;
          end else begin
            res_ran_q <= best_q.id;
            if (best_q.remaining == 8'd1) begin
              res_fin_q  <= 1'b1;
              res_comp_q <= psch_pkg::out_time(psch_pkg::widen_time(now_next));
              tat_q      <= psch_pkg::widen_time(now_next) -
                            psch_pkg::WIDE_BITS'(best_q.arrival);
              done_cnt_q <= done_cnt_q + 1'b1;
              state_q    <= ST_WAIT;
            end else begin
              state_q <= ST_RESP;
            end
          end
        end
        ST_WAIT: begin
          res_tat_q  <= psch_pkg::out_time(tat_q);
          res_wait_q <= (tat_q >= burst_w) ? psch_pkg::out_time(tat_q - burst_w) : '0;
          state_q    <= ST_RESP;
        end
        ST_RESP: begin
          if (resp_fire) begin
            out_valid_q <= 1'b1;
            out_ran_q   <= res_ran_q;
            out_idle_q  <= res_idle_q;
            out_time_q  <= res_time_q;
            out_fin_q   <= res_fin_q;
            out_comp_q  <= res_comp_q;
            out_tat_q   <= res_tat_q;
            out_wait_q  <= res_wait_q;
            out_all_q   <= (done_cnt_q == job_cnt_q);
            out_lerr_q  <= res_lerr_q;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign ran_job_o    = out_ran_q;
  assign idle_o       = out_idle_q;
  assign tick_time_o  = out_time_q;
  assign finished_o   = out_fin_q;
  assign completion_o = out_comp_q;
  assign turnaround_o = out_tat_q;
  assign waiting_o    = out_wait_q;
  assign all_done_o   = out_all_q;
  assign load_error_o = out_lerr_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (job_cnt_q <= psch_pkg::CNT_W'(psch_pkg::MAX_JOBS)) && (done_cnt_q <= job_cnt_q))
    else $error("Job or done count out of range.");

  a_fin_not_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && finished_o |-> !idle_o && (load_error_o == psch_pkg::LERR_OK))
    else $error("Finished result also flags idle or a load error.");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_ready_o)
    else $error("Input taken again before the previous word was resolved.");

  a_resp_loads_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    resp_fire |=> out_valid_o)
    else $error("Result step did not load the output register.");

endmodule
